// ----- src/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

	localparam int CFG_BITS = 7;
	localparam logic [CFG_BITS-1:0] WIN_RESET = 7'd3;

	// queue depths between the channels and the deque engine
	localparam int IN_DEPTH  = 4;
	localparam int OUT_DEPTH = 8;

	// cells per group in the front-select tree
	localparam int GRP = 8;

	typedef struct packed {
		logic                go;
		logic                start;
		logic [CFG_BITS-1:0] win;
	} swm_step_t;

endpackage

`default_nettype wire

// ----- src/swm_fifo.sv -----
`default_nettype none

module swm_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [AW-1:0]               wr_ptr_q;
	logic [AW-1:0]               rd_ptr_q;
	logic [CW-1:0]               cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- src/swm_cells.sv -----
`default_nettype none

// Deque kept as a shift line indexed by age: cell k holds the sample of age k,
// and its flag marks it as a live candidate.
module swm_cells #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32,
	parameter int NCELL       = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swm_pkg::swm_step_t                  step,
	input  logic [SAMPLE_BITS-1:0]              sample,
	output logic [NCELL-1:0]                    flag_q,
	output logic [NCELL-1:0][SAMPLE_BITS-1:0]   val_q,
	output logic                                res_q
);

	import swm_pkg::*;

	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (FW > CFG_BITS) ? FW : CFG_BITS;

	logic [CW-1:0]                      win_x;
	logic [CW-1:0]                      w_eff;
	logic [FW-1:0]                      fill_q;
	logic [FW-1:0]                      fill_base;
	logic [FW-1:0]                      fill_nx;
	logic                               has_res;
	logic [NCELL-1:0]                   flag_nx;
	logic [NCELL-1:0][SAMPLE_BITS-1:0]  val_nx;

	always_comb begin
		win_x = CW'(step.win);
		if (win_x == '0) begin
			w_eff = CW'(1);
		end else if (win_x > CW'(MAX_WINDOW)) begin
			w_eff = CW'(MAX_WINDOW);
		end else begin
			w_eff = win_x;
		end
		fill_base = step.start ? '0 : fill_q;
		fill_nx   = (fill_base == FW'(MAX_WINDOW)) ? fill_base : fill_base + FW'(1);
		has_res   = (CW'(fill_nx) >= w_eff);
	end

	// age every cell by one, drop the expired, drop older ones not above the sample, and on start drop all older ones
	always_comb begin
		flag_nx[0] = 1'b1;
		val_nx[0]  = sample;
		for (int k = 1; k < NCELL; k++) begin
			flag_nx[k] = flag_q[k-1] & ~step.start & (CW'(k) < w_eff) &
			             ($signed(val_q[k-1]) > $signed(sample));
			val_nx[k]  = val_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
			fill_q <= '0;
			res_q  <= 1'b0;
		end else begin
			res_q <= step.go & has_res;
			if (step.go) begin
				flag_q <= flag_nx;
				fill_q <= fill_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.go) begin
			val_q <= val_nx;
		end
	end

endmodule

`default_nettype wire

// ----- src/swm_reduce.sv -----
`default_nettype none

// Two-stage select of the oldest live candidate, which is the window maximum.
module swm_reduce #(
	parameter int SAMPLE_BITS = 32,
	parameter int NCELL       = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [NCELL-1:0]                    flag,
	input  logic [NCELL-1:0][SAMPLE_BITS-1:0]   val,
	output logic                                valid_s1,
	output logic                                valid_s2,
	output logic [SAMPLE_BITS-1:0]              max_s2
);

	import swm_pkg::*;

	localparam int NGRP = (NCELL + GRP - 1) / GRP;

	logic [NGRP-1:0]                    grp_hit;
	logic [NGRP-1:0][SAMPLE_BITS-1:0]   grp_val;
	logic [NGRP-1:0]                    grp_hit_s1;
	logic [NGRP-1:0][SAMPLE_BITS-1:0]   grp_val_s1;
	logic [SAMPLE_BITS-1:0]             pick;

	// later hits override: highest index is the oldest candidate
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_hit[g] = 1'b0;
			grp_val[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < NCELL) begin
					if (flag[g*GRP+j]) begin
						grp_hit[g] = 1'b1;
						grp_val[g] = val[g*GRP+j];
					end
				end
			end
		end
	end

	always_comb begin
		pick = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_hit_s1[g]) begin
				pick = grp_val_s1[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		grp_hit_s1 <= grp_hit;
		grp_val_s1 <= grp_val;
		max_s2     <= pick;
	end

endmodule

`default_nettype wire

// ----- src/sliding_window_maximum.sv -----
`default_nettype none

// Sliding-window maximum of a stream of signed samples.
// Input side is a queue: drive sample and start_req with push; the request is
// taken at a clock edge where push is high and full is low. start_req marks the
// first sample of a new sequence and clears the window history.
// Result side is a queue as well: while empty is low, window_max holds the oldest
// waiting result; it is taken at an edge where pop is high. A sample yields a
// result once window_len samples have arrived since the last start.
// window_len is written through cfg_wen/cfg_wdata while the block is idle;
// 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// An accepted sample passes the input queue, the cell line and both select stages
// on its way to the result queue. Throughput: one sample per cycle while the result
// queue has room, set by the age-indexed cell line that updates every candidate in
// a single step; the front-select tree behind it is pipelined. A stalled receiver
// fills the result queue; the engine holds requests in the input queue once the
// result queue has no room for those in flight, and full then rises. Reset empties
// both queues, clears the candidates and the sample count and sets window_len to 3.
module sliding_window_maximum #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          start_req,
	input  logic                          pop,
	output logic                          empty,
	output logic [SAMPLE_BITS-1:0]        window_max,
	input  logic                          cfg_wen,
	input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata
);

	import swm_pkg::*;

	localparam int NCELL = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
	localparam int OCW   = $clog2(OUT_DEPTH + 1);

	logic [CFG_BITS-1:0]               win_q;
	logic [SAMPLE_BITS:0]              in_rdata;
	logic                              in_empty;
	logic [OCW-1:0]                    out_count;
	logic [OCW:0]                      out_need;
	logic                              room;
	swm_step_t                         step;
	logic [NCELL-1:0]                  flag_q;
	logic [NCELL-1:0][SAMPLE_BITS-1:0] val_q;
	logic                              res_q;
	logic                              valid_s1;
	logic                              valid_s2;
	logic [SAMPLE_BITS-1:0]            max_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_wen) begin
			win_q <= cfg_wdata;
		end
	end

	swm_fifo #(
		.WIDTH(SAMPLE_BITS + 1),
		.DEPTH(IN_DEPTH)
	) u_in_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({start_req, sample}),
		.full  (full),
		.pop   (step.go),
		.rdata (in_rdata),
		.empty (in_empty),
		.count ()
	);

	// hold issue while the result queue cannot take everything in flight
	always_comb begin
		out_need = {1'b0, out_count} + (OCW+1)'(res_q) + (OCW+1)'(valid_s1) +
		           (OCW+1)'(valid_s2);
		room     = (out_need < (OCW+1)'(OUT_DEPTH));
		step.go    = ~in_empty & room;
		step.start = in_rdata[SAMPLE_BITS];
		step.win   = win_q;
	end

	swm_cells #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.NCELL      (NCELL)
	) u_cells (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.sample(in_rdata[SAMPLE_BITS-1:0]),
		.flag_q(flag_q),
		.val_q (val_q),
		.res_q (res_q)
	);

	swm_reduce #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.NCELL      (NCELL)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(res_q),
		.flag    (flag_q),
		.val     (val_q),
		.valid_s1(valid_s1),
		.valid_s2(valid_s2),
		.max_s2  (max_s2)
	);

	swm_fifo #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s2),
		.wdata (max_s2),
		.full  (),
		.pop   (pop),
		.rdata (window_max),
		.empty (empty),
		.count (out_count)
	);

endmodule

`default_nettype wire

// ----- src/swm_checker.sv -----
`default_nettype none

module swm_checker #(
	parameter int SAMPLE_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   push,
	input logic                   full,
	input logic                   pop,
	input logic                   empty,
	input logic [SAMPLE_BITS-1:0] window_max
);

	// both queues come out of reset drained
	a_reset_state: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not drained after reset");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(window_max))
		else $error("waiting result changed before pop");

	// the input queue fills only through an accepted request
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted request");

	// the result queue drains only through an accepted pop
	a_empty_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop && !empty))
		else $error("empty rose without an accepted pop");

endmodule

bind sliding_window_maximum swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);

`default_nettype wire

// ----- tb/sliding_window_maximum_test.sv -----
`default_nettype none

module sliding_window_maximum_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam int WIN_MAX      = 64;
	localparam int DATA_BITS    = 32;
	localparam int AGE_CAP      = 127;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 300000;

	// random phases: window setting, request count, sender idle %, receiver stall %
	localparam int NUM_PHASES = 9;
	localparam int RANDOM_WIN = -1;
	localparam int HOLD_PHASE = 2;
	localparam int PH_WIN   [NUM_PHASES] = '{1, 0, 1, 5, 64, 127, 65, RANDOM_WIN, 2};
	localparam int PH_COUNT [NUM_PHASES] = '{120, 60, 150, 120, 200, 100, 60, 120, 120};
	localparam int PH_IDLE  [NUM_PHASES] = '{0, 87, 0, 0, 10, 0, 87, 10, 0};
	localparam int PH_STALL [NUM_PHASES] = '{0, 0, 0, 87, 10, 0, 0, 10, 87};

	localparam int NUM_DIRECTED = 23;
	localparam logic [DATA_BITS-1:0] DIR_SAMPLE [NUM_DIRECTED] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		32'd5, 32'd5, 32'd5,
		32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		32'd10, 32'd9, 32'd8, 32'd7, 32'd6,
		32'd1, 32'd2, 32'd3, 32'd4
	};
	localparam bit DIR_START [NUM_DIRECTED] = '{
		1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b1, 1'b1, 1'b0, 1'b0
	};

	class swm_scoreboard;
		logic signed [DATA_BITS-1:0] cand_val [WIN_MAX];
		int                          cand_age [WIN_MAX];
		int                          cand_cnt;
		int                          fill_cnt;
		logic [CFG_BITS-1:0]         win_reg;
		logic [DATA_BITS-1:0]        expected_max [$];
		int                          errors;

		function new();
			win_reg  = WIN_RESET;
			cand_cnt = 0;
			fill_cnt = 0;
			errors   = 0;
		endfunction

		function void set_window(logic [CFG_BITS-1:0] v);
			win_reg = v;
		endfunction

		function void note_sample(logic [DATA_BITS-1:0] s, bit st);
			int w;
			int drop;
			w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
			if (st) begin
				cand_cnt = 0;
				fill_cnt = 0;
			end
			for (int i = 0; i < cand_cnt; i++)
				if (cand_age[i] < AGE_CAP)
					cand_age[i]++;
			// expired entries sit at the front
			drop = 0;
			while (drop < cand_cnt && cand_age[drop] >= w)
				drop++;
			for (int i = 0; i < cand_cnt - drop; i++) begin
				cand_val[i] = cand_val[i + drop];
				cand_age[i] = cand_age[i + drop];
			end
			cand_cnt -= drop;
			while (cand_cnt > 0 && cand_val[cand_cnt - 1] <= $signed(s))
				cand_cnt--;
			if (cand_cnt < WIN_MAX) begin
				cand_val[cand_cnt] = s;
				cand_age[cand_cnt] = 0;
				cand_cnt++;
			end
			if (fill_cnt < WIN_MAX)
				fill_cnt++;
			if (fill_cnt >= w)
				expected_max.insert(expected_max.size(), cand_val[0]);
		endfunction

		function void check_max(logic [DATA_BITS-1:0] got);
			logic [DATA_BITS-1:0] exp_val;
			if (expected_max.size() == 0) begin
				$error("window_max: no result expected, got %0d", $signed(got));
				errors++;
			end else begin
				exp_val = expected_max[0];
				expected_max.delete(0);
				if (got !== exp_val) begin
					$error("window_max: expected %0d, got %0d",
						$signed(exp_val), $signed(got));
					errors++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [DATA_BITS-1:0] sample = '0;
	logic                 start_req = 1'b0;
	logic                 pop = 1'b0;
	logic                 empty;
	logic [DATA_BITS-1:0] window_max;
	logic                 cfg_wen = 1'b0;
	logic [CFG_BITS-1:0]  cfg_wdata = '0;

	swm_scoreboard sb = new();
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	bit            hold_armed = 1'b0;
	int            cycle_count = 0;

	sliding_window_maximum #(
		.MAX_WINDOW(WIN_MAX),
		.SAMPLE_BITS(DATA_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.start_req(start_req),
		.pop(pop),
		.empty(empty),
		.window_max(window_max),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		int hold_count;
		hold_count = 0;
		forever begin
			@(negedge clk);
			if (hold_armed && hold_count < HOLD_CYCLES) begin
				hold_count++;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_max(window_max);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [DATA_BITS-1:0] s, input bit st);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		sample    <= s;
		start_req <= st;
		do
			@(posedge clk);
		while (full);
		sb.note_sample(s, st);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.expected_max.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_window(input logic [CFG_BITS-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		sb.set_window(v);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [DATA_BITS-1:0] pick_sample(logic [DATA_BITS-1:0] prev);
		logic [DATA_BITS-1:0] r;
		case ($urandom_range(0, 9))
			0, 1, 2: r = $urandom;
			3, 4:    r = $urandom_range(0, 8) - 4;
			5, 6:    r = prev - $urandom_range(0, 3);
			7:       r = prev + $urandom_range(1, 3);
			8: begin
				case ($urandom_range(0, 3))
					0:       r = 32'h8000_0000;
					1:       r = 32'h7FFF_FFFF;
					2:       r = '0;
					default: r = '1;
				endcase
			end
			default: r = prev;
		endcase
		return r;
	endfunction

	initial begin
		int                   win;
		int                   eff;
		logic [DATA_BITS-1:0] s;
		bit                   st;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests at the reset window of three
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_request(DIR_SAMPLE[i], DIR_START[i]);
		push <= 1'b0;

		s = '0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			win = (PH_WIN[p] == RANDOM_WIN) ? $urandom_range(2, 20) : PH_WIN[p];
			write_window(win[CFG_BITS-1:0]);
			eff = (win == 0) ? 1 : ((win > WIN_MAX) ? WIN_MAX : win);
			tx_idle_pct  = PH_IDLE[p];
			rx_stall_pct = PH_STALL[p];
			if (p == HOLD_PHASE)
				hold_armed = 1'b1;
			// the window carries over unless a start comes
			for (int i = 0; i < PH_COUNT[p]; i++) begin
				s  = pick_sample(s);
				st = ($urandom_range(0, 2 * eff + 3) == 0);
				send_request(s, st);
			end
			push <= 1'b0;
		end

		wait_idle();
		if (sb.errors == 0 && sb.expected_max.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
